FILE: rtl/core/i2cms_pkg.sv
package i2cms_pkg;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned TICK_W  = 8;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 16;

    localparam logic [CMD_W-1:0] OP_IDLE  = 3'd0;
    localparam logic [CMD_W-1:0] OP_START = 3'd1;
    localparam logic [CMD_W-1:0] OP_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] OP_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] OP_READ  = 3'd4;
    localparam logic [CMD_W-1:0] OP_SACK  = 3'd5;
    localparam logic [CMD_W-1:0] OP_RACK  = 3'd6;

    localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 8'd10;
    localparam logic [BYTE_W-1:0] RX_MSB_MASK     = 8'h80;

    // line actions for one phase
    typedef struct packed {
        logic              scl_we;
        logic              scl_val;
        logic              sda_we;
        logic              sda_val;
        logic              rx_we;
        logic [BYTE_W-1:0] rx_mask;
        logic              ack_we;
        logic              ack_val;
    } phase_act_t;

    function automatic logic [IDX_W-1:0] phase_total(input logic [CMD_W-1:0] op);
        logic [IDX_W-1:0] n;
        unique case (op)
            OP_START: n = 5'd4;
            OP_STOP:  n = 5'd3;
            OP_WRITE: n = 5'd24;
            OP_READ:  n = 5'd25;
            OP_SACK:  n = 5'd3;
            OP_RACK:  n = 5'd4;
            default:  n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/core/i2c_master_bit_sequencer_core.sv
// A tick item accepted at an edge has its result valid after that edge.
// Throughput: one item per cycle; the sequencer state doubles as the result register,
// so a new item is taken whenever the result register is empty or being drained.
// Reset (rst_n, async, active low): lines released high, sequencer idle, no result
// pending, phase_ticks back to 10.
module i2c_master_bit_sequencer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // command[2:0], tx_byte[10:3], ack_bit[11], sda_in[12], zero pad
    input  logic [i2cms_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // scl_level[0], sda_level[1], busy_res[2], done_res[3], rx_byte[11:4], rx_ack[12], zero pad
    output logic [i2cms_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [i2cms_pkg::TICK_W-1:0]     cfg_wdata
);
    import i2cms_pkg::*;

    logic [TICK_W-1:0] phase_ticks_reg;
    logic [TICK_W-1:0] hold;
    logic              m_valid_reg, m_valid_next;
    logic              accept;
    logic              scl_level, sda_level, busy_res, done_res, rx_ack;
    logic [BYTE_W-1:0] rx_byte;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign hold          = (phase_ticks_reg == '0) ? 8'd1 : phase_ticks_reg;
    assign m_valid_next  = accept || (m_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                phase_ticks_reg <= cfg_wdata;
            m_valid_reg <= m_valid_next;
        end
    end

    i2cms_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .hold      (hold),
        .command   (s_axis_tdata[2:0]),
        .tx_byte   (s_axis_tdata[10:3]),
        .ack_bit   (s_axis_tdata[11]),
        .sda_in    (s_axis_tdata[12]),
        .scl_level (scl_level),
        .sda_level (sda_level),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .rx_byte   (rx_byte),
        .rx_ack    (rx_ack)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, rx_ack, rx_byte, done_res, busy_res, sda_level, scl_level};

endmodule

FILE: rtl/core/i2cms_phase.sv
module i2cms_phase (
    input  logic [i2cms_pkg::CMD_W-1:0]  op,
    input  logic [i2cms_pkg::IDX_W-1:0]  idx,
    input  logic [i2cms_pkg::BYTE_W-1:0] tx_byte,
    input  logic                         sack_level,
    input  logic                         sda_in,
    output i2cms_pkg::phase_act_t        act
);
    import i2cms_pkg::*;

    logic [IDX_W-1:0] rel;
    logic [8:0]       prod;
    logic [3:0]       quot;
    logic [2:0]       bit_n;
    logic [IDX_W-1:0] quot3;
    logic [IDX_W-1:0] rem_full;
    logic [1:0]       sub;

    // rel / 3 as (rel * 11) >> 5, exact for rel < 32
    assign rel      = (op == OP_READ) ? idx - 5'd1 : idx;
    assign prod     = {4'b0, rel} * 9'd11;
    assign quot     = prod[8:5];
    assign bit_n    = quot[2:0];
    assign quot3    = {quot, 1'b0} + {1'b0, quot};
    assign rem_full = rel - quot3;
    assign sub      = rem_full[1:0];

    always_comb
    begin
        act = '0;
        unique case (op)
            OP_START:
            begin
                case (idx)
                    5'd0:    begin act.sda_we = 1'b1; act.sda_val = 1'b1; end
                    5'd1:    begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
                    5'd2:    begin act.sda_we = 1'b1; act.sda_val = 1'b0; end
                    default: begin act.scl_we = 1'b1; act.scl_val = 1'b0; end
                endcase
            end
            OP_STOP:
            begin
                case (idx)
                    5'd0:    begin act.sda_we = 1'b1; act.sda_val = 1'b0; end
                    5'd1:    begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
                    default: begin act.sda_we = 1'b1; act.sda_val = 1'b1; end
                endcase
            end
            OP_WRITE:
            begin
                case (sub)
                    2'd0:    begin act.sda_we = 1'b1; act.sda_val = tx_byte[3'd7 - bit_n]; end
                    2'd1:    begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
                    default: begin act.scl_we = 1'b1; act.scl_val = 1'b0; end
                endcase
            end
            OP_READ:
            begin
                if (idx == 5'd0)
                begin
                    act.sda_we  = 1'b1;
                    act.sda_val = 1'b1;
                end
                else
                begin
                    case (sub)
                        2'd0:
                        begin
                            act.scl_we  = 1'b1;
                            act.scl_val = 1'b1;
                        end
                        2'd1:
                        begin
                            act.rx_we   = sda_in;
                            act.rx_mask = RX_MSB_MASK >> bit_n;
                        end
                        default:
                        begin
                            act.scl_we  = 1'b1;
                            act.scl_val = 1'b0;
                        end
                    endcase
                end
            end
            OP_SACK:
            begin
                case (idx)
                    5'd0:    begin act.sda_we = 1'b1; act.sda_val = sack_level; end
                    5'd1:    begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
                    default: begin act.scl_we = 1'b1; act.scl_val = 1'b0; end
                endcase
            end
            OP_RACK:
            begin
                case (idx)
                    5'd0:    begin act.sda_we = 1'b1; act.sda_val = 1'b1; end
                    5'd1:    begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
                    5'd2:    begin act.ack_we = 1'b1; act.ack_val = sda_in; end
                    default: begin act.scl_we = 1'b1; act.scl_val = 1'b0; end
                endcase
            end
            default:
            begin
                act = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/i2cms_seq.sv
module i2cms_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [i2cms_pkg::TICK_W-1:0]  hold,
    input  logic [i2cms_pkg::CMD_W-1:0]   command,
    input  logic [i2cms_pkg::BYTE_W-1:0]  tx_byte,
    input  logic                          ack_bit,
    input  logic                          sda_in,
    output logic                          scl_level,
    output logic                          sda_level,
    output logic                          busy_res,
    output logic                          done_res,
    output logic [i2cms_pkg::BYTE_W-1:0]  rx_byte,
    output logic                          rx_ack
);
    import i2cms_pkg::*;

    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic [CMD_W-1:0]  op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [TICK_W-1:0] wait_reg, wait_next;
    logic [BYTE_W-1:0] tx_reg, tx_next;
    logic              sack_reg, sack_next;
    logic [BYTE_W-1:0] rx_reg, rx_next;
    logic              ack_reg, ack_next;
    logic              done_reg, done_next;

    logic              active;
    logic              starting;
    logic [TICK_W-1:0] wait_dec;
    logic [IDX_W-1:0]  idx_inc;
    logic              finish;
    logic              run;
    logic [CMD_W-1:0]  act_op;
    logic [IDX_W-1:0]  act_idx;
    logic [BYTE_W-1:0] rx_base;
    phase_act_t        act;

    assign active   = (op_reg != OP_IDLE);
    assign starting = !active && (command >= OP_START) && (command <= OP_RACK);
    assign wait_dec = wait_reg - 8'd1;
    assign idx_inc  = idx_reg + 5'd1;
    assign finish   = active && (wait_dec == '0) && (idx_inc >= phase_total(op_reg));
    assign run      = starting || (active && (wait_dec == '0) && !finish);
    assign act_op   = starting ? command : op_reg;
    assign act_idx  = starting ? '0 : idx_inc;
    assign tx_next  = (starting && command == OP_WRITE) ? tx_byte : tx_reg;
    assign sack_next = (starting && command == OP_SACK) ? ack_bit : sack_reg;
    assign rx_base  = (starting && command == OP_READ) ? '0 : rx_reg;

    i2cms_phase u_phase (
        .op         (act_op),
        .idx        (act_idx),
        .tx_byte    (tx_next),
        .sack_level (sack_next),
        .sda_in     (sda_in),
        .act        (act)
    );

    always_comb
    begin
        scl_next  = scl_reg;
        sda_next  = sda_reg;
        op_next   = op_reg;
        idx_next  = idx_reg;
        wait_next = wait_reg;
        rx_next   = rx_base;
        ack_next  = ack_reg;
        done_next = 1'b0;
        if (active)
        begin
            wait_next = wait_dec;
            if (finish)
            begin
                op_next   = OP_IDLE;
                idx_next  = '0;
                done_next = 1'b1;
            end
            else if (wait_dec == '0)
            begin
                idx_next = idx_inc;
            end
        end
        else if (starting)
        begin
            op_next  = command;
            idx_next = '0;
        end
        if (run)
        begin
            wait_next = hold;
            if (act.scl_we) scl_next = act.scl_val;
            if (act.sda_we) sda_next = act.sda_val;
            if (act.rx_we)  rx_next  = rx_base | act.rx_mask;
            if (act.ack_we) ack_next = act.ack_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg  <= 1'b1;
            sda_reg  <= 1'b1;
            op_reg   <= OP_IDLE;
            idx_reg  <= '0;
            wait_reg <= '0;
            tx_reg   <= '0;
            sack_reg <= 1'b0;
            rx_reg   <= '0;
            ack_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (step)
        begin
            scl_reg  <= scl_next;
            sda_reg  <= sda_next;
            op_reg   <= op_next;
            idx_reg  <= idx_next;
            wait_reg <= wait_next;
            tx_reg   <= tx_next;
            sack_reg <= sack_next;
            rx_reg   <= rx_next;
            ack_reg  <= ack_next;
            done_reg <= done_next;
        end
    end

    assign scl_level = scl_reg;
    assign sda_level = sda_reg;
    assign busy_res  = active;
    assign done_res  = done_reg;
    assign rx_byte   = rx_reg;
    assign rx_ack    = ack_reg;

endmodule

FILE: rtl/core/i2cms_checker.sv
module i2cms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // every accepted item yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted item gave no result");

    // done marks the end of a sequence, never while still busy
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[2]))
        else $error("done while busy");

    // an empty output side never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: test/tb_i2c_master_bit_sequencer_core.sv
`timescale 1ns / 1ps

module tb_i2c_master_bit_sequencer_core;

    import i2cms_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE   = OP_IDLE;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned STALL_CYCLES = 200;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned SMALL_BUDGET = 60;
    localparam int unsigned SLOW_BUDGET  = 150;
    localparam int          DIR_FAST_ROW = 3;
    localparam int          SLOW_PHASE   = 3;

    // ack[12], rx[11:4], done[3], busy[2], sda[1], scl[0]
    localparam logic [15:0] IDLE_RES  = 16'h1003;
    localparam logic [15:0] START_RES = 16'h1007;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] tx;
        logic              ack;
        logic              sda;
        logic [CMD_W-1:0]  busy_cmd;
        logic              typed;
        logic [15:0]       want;
    } dir_row_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] tx;
        logic              ack;
    } planned_cmd_t;

    localparam int DIR_ROWS = 18;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{CMD_NONE,   8'h00, 1'b0, 1'b0, CMD_NONE, 1'b1, IDLE_RES},
        '{CMD_UNUSED, 8'hFF, 1'b1, 1'b1, CMD_NONE, 1'b1, IDLE_RES},
        '{OP_START,   8'h00, 1'b0, 1'b1, OP_WRITE, 1'b1, START_RES},
        '{OP_WRITE,   8'h00, 1'b0, 1'b0, CMD_NONE, 1'b0, 16'h0000},
        '{OP_RACK,    8'h00, 1'b0, 1'b0, CMD_NONE, 1'b0, 16'h0000},
        '{OP_WRITE,   8'hFF, 1'b1, 1'b1, CMD_NONE, 1'b0, 16'h0000},
        '{OP_RACK,    8'h00, 1'b0, 1'b1, CMD_NONE, 1'b0, 16'h0000},
        '{OP_WRITE,   8'hA5, 1'b0, 1'b0, OP_STOP,  1'b0, 16'h0000},
        '{OP_READ,    8'h00, 1'b0, 1'b1, CMD_NONE, 1'b0, 16'h0000},
        '{OP_SACK,    8'h00, 1'b0, 1'b0, CMD_NONE, 1'b0, 16'h0000},
        '{OP_READ,    8'hFF, 1'b1, 1'b0, CMD_NONE, 1'b0, 16'h0000},
        '{OP_SACK,    8'h00, 1'b1, 1'b1, CMD_NONE, 1'b0, 16'h0000},
        '{OP_STOP,    8'h00, 1'b0, 1'b0, CMD_NONE, 1'b0, 16'h0000},
        '{CMD_UNUSED, 8'h00, 1'b0, 1'b0, CMD_NONE, 1'b0, 16'h0000},
        '{OP_START,   8'h00, 1'b0, 1'b0, CMD_NONE, 1'b0, 16'h0000},
        '{OP_READ,    8'h00, 1'b0, 1'b1, OP_READ,  1'b0, 16'h0000},
        '{OP_RACK,    8'h00, 1'b0, 1'b0, OP_RACK,  1'b0, 16'h0000},
        '{OP_STOP,    8'h00, 1'b0, 1'b1, OP_START, 1'b0, 16'h0000}
    };

    localparam int PHASES = 6;
    localparam logic [TICK_W-1:0] PHASE_SET [PHASES] = '{
        8'd1, 8'd0, 8'd3, 8'd30, 8'd2, 8'd1
    };

    logic clk = 1'b0;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic cfg_we;
    logic [TICK_W-1:0] cfg_wdata;

    // predicted sequencer state
    logic              m_scl;
    logic              m_sda;
    logic [CMD_W-1:0]  m_op;
    logic [IDX_W-1:0]  m_idx;
    logic [TICK_W-1:0] m_wait;
    logic [BYTE_W-1:0] m_tx;
    logic              m_ack_lvl;
    logic [BYTE_W-1:0] m_rx;
    logic              m_ack_seen;
    logic [TICK_W-1:0] m_ticks;

    logic [15:0]  line_state_q [$];
    planned_cmd_t plan_q [$];
    logic [15:0]  want_res;
    int unsigned  fail_count = 0;
    int unsigned  cycle_count = 0;
    bit           stall_req = 1'b0;
    bit           quiet_tail = 1'b0;

    i2c_master_bit_sequencer_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned op_phases(input logic [CMD_W-1:0] op);
        case (op)
            OP_START: return 4;
            OP_STOP:  return 3;
            OP_WRITE: return 24;
            OP_READ:  return 25;
            OP_SACK:  return 3;
            OP_RACK:  return 4;
            default:  return 0;
        endcase
    endfunction

    task automatic line_phase(input logic [IDX_W-1:0] idx, input logic sda_now);
        logic [IDX_W-1:0] bit_n;
        logic [IDX_W-1:0] sub;
        logic [IDX_W-1:0] rd_idx;
        bit_n = IDX_W'(idx / 3);
        sub = IDX_W'(idx % 3);
        rd_idx = idx - 1'b1;
        case (m_op)
            OP_START:
            begin
                if (idx == 0) m_sda = 1'b1;
                else if (idx == 1) m_scl = 1'b1;
                else if (idx == 2) m_sda = 1'b0;
                else m_scl = 1'b0;
            end
            OP_STOP:
            begin
                if (idx == 0) m_sda = 1'b0;
                else if (idx == 1) m_scl = 1'b1;
                else m_sda = 1'b1;
            end
            OP_WRITE:
            begin
                if (sub == 0) m_sda = m_tx[3'(7 - bit_n)];
                else if (sub == 1) m_scl = 1'b1;
                else m_scl = 1'b0;
            end
            OP_READ:
            begin
                if (idx == 0)
                begin
                    m_sda = 1'b1;
                end
                else
                begin
                    bit_n = IDX_W'(rd_idx / 3);
                    sub = IDX_W'(rd_idx % 3);
                    if (sub == 0) m_scl = 1'b1;
                    else if (sub == 1)
                    begin
                        if (sda_now) m_rx = m_rx | (RX_MSB_MASK >> bit_n);
                    end
                    else m_scl = 1'b0;
                end
            end
            OP_SACK:
            begin
                if (idx == 0) m_sda = m_ack_lvl;
                else if (idx == 1) m_scl = 1'b1;
                else m_scl = 1'b0;
            end
            OP_RACK:
            begin
                if (idx == 0) m_sda = 1'b1;
                else if (idx == 1) m_scl = 1'b1;
                else if (idx == 2) m_ack_seen = sda_now;
                else m_scl = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic sequencer_tick(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] tx,
                                  input logic ack, input logic sda_now,
                                  output logic [15:0] res);
        logic done;
        logic [TICK_W-1:0] hold;
        done = 1'b0;
        hold = (m_ticks == 0) ? 8'd1 : m_ticks;
        if (m_op != OP_IDLE)
        begin
            m_wait = m_wait - 1'b1;
            if (m_wait == 0)
            begin
                m_idx = m_idx + 1'b1;
                if (m_idx >= op_phases(m_op))
                begin
                    m_op = OP_IDLE;
                    m_idx = '0;
                    done = 1'b1;
                end
                else
                begin
                    line_phase(m_idx, sda_now);
                    m_wait = hold;
                end
            end
        end
        else if (cmd >= OP_START && cmd <= OP_RACK)
        begin
            m_op = cmd;
            m_idx = '0;
            if (cmd == OP_WRITE) m_tx = tx;
            if (cmd == OP_SACK) m_ack_lvl = ack;
            if (cmd == OP_READ) m_rx = '0;
            line_phase('0, sda_now);
            m_wait = hold;
        end
        res = {3'b000, m_ack_seen, m_rx, done, m_op != OP_IDLE, m_sda, m_scl};
    endtask

    // called and returns at a falling edge
    task automatic drive_tick(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] tx,
                              input logic ack, input logic sda_now,
                              input logic typed, input logic [15:0] typed_res);
        logic [15:0] pred;
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, sda_now, ack, tx, cmd};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sequencer_tick(cmd, tx, ack, sda_now, pred);
        line_state_q.push_back(typed ? typed_res : pred);
        @(negedge clk);
    endtask

    task automatic set_ticks(input logic [TICK_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (line_state_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        m_ticks = value;
    endtask

    task automatic plan_next();
        logic [6:0] addr;
        logic rd;
        int n;
        if ($urandom_range(0, 3) == 0)
        begin
            plan_q.push_back('{3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1))});
        end
        else
        begin
            addr = 7'($urandom_range(0, 127));
            rd = 1'($urandom_range(0, 1));
            n = $urandom_range(1, 3);
            plan_q.push_back('{OP_START, 8'h00, 1'b0});
            plan_q.push_back('{OP_WRITE, {addr, rd}, 1'b0});
            plan_q.push_back('{OP_RACK, 8'h00, 1'b0});
            for (int i = 0; i < n; i++)
            begin
                if (rd)
                begin
                    plan_q.push_back('{OP_READ, 8'h00, 1'b0});
                    plan_q.push_back('{OP_SACK, 8'h00, i == n - 1});
                end
                else
                begin
                    plan_q.push_back('{OP_WRITE, 8'($urandom_range(0, 255)), 1'b0});
                    plan_q.push_back('{OP_RACK, 8'h00, 1'b0});
                end
            end
            plan_q.push_back('{OP_STOP, 8'h00, 1'b0});
        end
    endtask

    task automatic random_tick();
        planned_cmd_t pc;
        pc.cmd = CMD_NONE;
        pc.tx = 8'($urandom_range(0, 255));
        pc.ack = 1'($urandom_range(0, 1));
        if (m_op == OP_IDLE)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                pc.cmd = $urandom_range(0, 1) ? CMD_UNUSED : CMD_NONE;
            end
            else
            begin
                if (plan_q.size() == 0) plan_next();
                pc = plan_q.pop_front();
            end
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            pc.cmd = 3'($urandom_range(0, 7));
        end
        drive_tick(pc.cmd, pc.tx, pc.ack, 1'($urandom_range(0, 1)), 1'b0, 16'h0000);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (line_state_q.size() == 0)
            begin
                $error("result with nothing expected: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want_res = line_state_q.pop_front();
                check_field("scl_level", want_res[0], m_axis_tdata[0]);
                check_field("sda_level", want_res[1], m_axis_tdata[1]);
                check_field("busy_res", want_res[2], m_axis_tdata[2]);
                check_field("done_res", want_res[3], m_axis_tdata[3]);
                check_field("rx_byte", want_res[11:4], m_axis_tdata[11:4]);
                check_field("rx_ack", want_res[12], m_axis_tdata[12]);
            end
        end
    end

    // result side
    initial
    begin
        bit stall_done;
        stall_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_req && !stall_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                stall_done = 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [TICK_W-1:0] ticks;
        int unsigned budget;
        int unsigned n;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        m_scl = 1'b1;
        m_sda = 1'b1;
        m_op = OP_IDLE;
        m_idx = '0;
        m_wait = '0;
        m_tx = '0;
        m_ack_lvl = 1'b0;
        m_rx = '0;
        m_ack_seen = 1'b1;
        m_ticks = PHASE_TICKS_RST;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first rows run at the reset hold time, the rest at one tick per phase
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i == DIR_FAST_ROW) set_ticks(8'd1);
            drive_tick(DIR_TABLE[i].cmd, DIR_TABLE[i].tx, DIR_TABLE[i].ack, DIR_TABLE[i].sda,
                       DIR_TABLE[i].typed, DIR_TABLE[i].want);
            while (m_op != OP_IDLE)
                drive_tick(DIR_TABLE[i].busy_cmd, 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), DIR_TABLE[i].sda, 1'b0, 16'h0000);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            ticks = (ph == 4) ? 8'($urandom_range(2, 6)) : PHASE_SET[ph];
            set_ticks(ticks);
            budget = SMALL_BUDGET;
            if (ph == 0) stall_req = 1'b1;
            if (ph == PHASES - 1) quiet_tail = 1'b1;
            if (ph == SLOW_PHASE)
            begin
                plan_q.delete();
                plan_q.push_back('{OP_START, 8'h00, 1'b0});
                plan_q.push_back('{OP_STOP, 8'h00, 1'b0});
                budget = SLOW_BUDGET;
            end
            n = 0;
            while (n < budget || m_op != OP_IDLE)
            begin
                random_tick();
                n++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (line_state_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
